FILE: rtl/core/kvt_pkg.sv
// Shared constants, types and command/status structs for the key-value table.
// No dependencies; kvt_ctrl, kvt_dpath and key_value_table import this package.
`default_nettype none

package kvt_pkg;

   localparam int ENTRIES = 64;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int KEY_W   = 31;
   localparam int VAL_W   = 31;
   localparam int TYPE_W  = 2;
   localparam int WORD_W  = 1 + KEY_W + VAL_W;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   // request type codes
   localparam logic [TYPE_W-1:0] REQ_PUT    = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_GET    = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_en;
      logic load_en;
      logic scan_en;
      logic resp_en;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic scan_done;
   } stat_type;

endpackage : kvt_pkg

`default_nettype wire

FILE: rtl/core/kvt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module kvt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule : kvt_ram

`default_nettype wire

FILE: rtl/core/kvt_ctrl.sv
// Controller FSM for the key-value table: clear pass, idle, scan, respond.
// Depends on kvt_pkg.
`default_nettype none

module kvt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire kvt_pkg::stat_type stat,
   output      kvt_pkg::cmd_type  cmd,
   output      logic              busy
);

   import kvt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
         end
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.load_en = start;
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
         end
         ST_RESP: begin
            cmd.resp_en = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule : kvt_ctrl

`default_nettype wire

FILE: rtl/core/kvt_dpath.sv
// Datapath for the key-value table: request register, entry RAM, scan compare,
// hit/free tracking, write-back and result. Depends on kvt_pkg and kvt_ram.
`default_nettype none

module kvt_dpath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire kvt_pkg::cmd_type             cmd,
   output      kvt_pkg::stat_type            stat,
   input  wire logic [kvt_pkg::TYPE_W-1:0]   req_type,
   input  wire logic [kvt_pkg::KEY_W-1:0]    req_key,
   input  wire logic [kvt_pkg::VAL_W-1:0]    req_value,
   output      logic                         rsp_strobe,
   output      logic                         rsp_found,
   output      logic [kvt_pkg::VAL_W-1:0]    rsp_read_value,
   output      logic                         rsp_status
);

   import kvt_pkg::*;

   // latched request word
   logic [TYPE_W-1:0] type_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [VAL_W-1:0]  value_ff;

   // scan / clear pointer: during a scan, index of the entry whose word is on rdata
   logic [IDX_W-1:0]  ptr_ff, ptr_in;

   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [VAL_W-1:0]  hit_value_ff, hit_value_in;
   logic              free_ff, free_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;

   // RAM ports
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic [IDX_W-1:0]  ram_raddr;
   logic [WORD_W-1:0] ram_rdata;

   logic              rd_valid;
   logic [KEY_W-1:0]  rd_key;
   logic [VAL_W-1:0]  rd_value;
   logic              match;
   logic              known_type;

   kvt_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // word layout: valid | key | value
   assign rd_valid = ram_rdata[WORD_W-1];
   assign rd_key   = ram_rdata[KEY_W+VAL_W-1:VAL_W];
   assign rd_value = ram_rdata[VAL_W-1:0];
   assign match    = rd_valid && (rd_key == key_ff);

   assign known_type = type_ff inside {REQ_PUT, REQ_GET, REQ_REMOVE};

   assign stat.clear_last = (ptr_ff == LAST_IDX);
   assign stat.scan_done  = match || (ptr_ff == LAST_IDX);

   // read address runs one ahead of the word being compared
   assign ram_raddr = cmd.scan_en ? (ptr_ff + IDX_W'(1)) : '0;

   always_comb begin
      ptr_in       = ptr_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_value_in = hit_value_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      if (cmd.clear_en) begin
         ptr_in = ptr_ff + IDX_W'(1);
      end else if (cmd.load_en) begin
         ptr_in  = '0;
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else if (cmd.scan_en) begin
         ptr_in = ptr_ff + IDX_W'(1);
         if (match && !hit_ff) begin
            hit_in       = 1'b1;
            hit_idx_in   = ptr_ff;
            hit_value_in = rd_value;
         end
         if (!rd_valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         ptr_ff  <= ptr_in;
         hit_ff  <= hit_in;
         free_ff <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff   <= hit_idx_in;
      hit_value_ff <= hit_value_in;
      free_idx_ff  <= free_idx_in;
      if (cmd.load_en) begin
         type_ff  <= req_type;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
   end

   // write-back: clear pass, or the update of a finished request
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = hit_idx_ff;
      ram_wdata = {1'b1, key_ff, value_ff};
      if (cmd.clear_en) begin
         ram_we    = 1'b1;
         ram_waddr = ptr_ff;
         ram_wdata = '0;
      end else if (cmd.resp_en) begin
         if (type_ff == REQ_PUT) begin
            if (hit_ff) begin
               ram_we = 1'b1;
            end else if (free_ff) begin
               ram_we    = 1'b1;
               ram_waddr = free_idx_ff;
            end
         end else if (type_ff == REQ_REMOVE) begin
            ram_we    = hit_ff;
            ram_wdata = {1'b0, key_ff, value_ff};
         end
      end
   end

   assign rsp_strobe     = cmd.resp_en;
   assign rsp_found      = hit_ff && known_type;
   assign rsp_read_value = (hit_ff && (type_ff == REQ_GET)) ? hit_value_ff : '0;
   assign rsp_status     = (type_ff == REQ_PUT) && !hit_ff && !free_ff;

endmodule : kvt_dpath

`default_nettype wire

FILE: rtl/core/key_value_table.sv
// Top level of the key-value table: wires the controller FSM to the datapath.
// Depends on kvt_pkg, kvt_ctrl, kvt_dpath (and kvt_ram below it).
//
//  channel   ports                                          handshake
//  --------  ---------------------------------------------  -----------------------
//  request   req_type, req_key, req_value                   start high, busy low
//  response  rsp_found, rsp_read_value, rsp_status          rsp_strobe, one cycle
//
// Flow: a word is taken in idle; the entries are then read from one RAM
// port, one entry a cycle, until the key matches or the last entry is seen,
// then comes a response state that also writes back. A request scans up to
// the matching slot, or all ENTRIES slots on a miss. Reset: a clearing pass
// over all ENTRIES slots zeroes the valid marks; busy is high throughout.
// Responses cannot be stalled; busy holds off requests.
`default_nettype none

module key_value_table (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output      logic                        busy,
   input  wire logic [kvt_pkg::TYPE_W-1:0]  req_type,
   input  wire logic [kvt_pkg::KEY_W-1:0]   req_key,
   input  wire logic [kvt_pkg::VAL_W-1:0]   req_value,
   output      logic                        rsp_strobe,
   output      logic                        rsp_found,
   output      logic [kvt_pkg::VAL_W-1:0]   rsp_read_value,
   output      logic                        rsp_status
);

   import kvt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencing: clear pass, accept, scan, respond
   kvt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // entry RAM, key compare, hit and free-slot tracking, result
   kvt_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_type       (req_type),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_found      (rsp_found),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status)
   );

endmodule : key_value_table

`default_nettype wire

FILE: test/key_value_table_tb.sv
// Self-checking testbench for key_value_table: put, get and remove words are
// checked against an in-bench model of the 64-entry associative table.
// Depends on kvt_pkg and the key_value_table RTL only.
module key_value_table_tb;

   localparam int ENTRIES = kvt_pkg::ENTRIES;
   localparam int KEY_W   = kvt_pkg::KEY_W;
   localparam int VAL_W   = kvt_pkg::VAL_W;
   localparam int TYPE_W  = kvt_pkg::TYPE_W;

   // the one request code the package leaves out: the block must ignore it
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

   localparam logic [KEY_W-1:0] FIELD_MAX = '1;
   localparam int KEY_POOL     = 96;            // more keys than slots, so the table fills
   localparam int SETTLE_TICKS = ENTRIES + 8;   // longest scan plus response, with margin

   typedef struct packed {
      logic             found;
      logic [VAL_W-1:0] read_value;
      logic             status;
   } kv_reply_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [TYPE_W-1:0]   req_type;
   logic [KEY_W-1:0]    req_key;
   logic [VAL_W-1:0]    req_value;
   logic                rsp_strobe;
   logic                rsp_found;
   logic [VAL_W-1:0]    rsp_read_value;
   logic                rsp_status;

   // model of the table contents, updated as each word is accepted
   logic [KEY_W-1:0]    stored_key   [ENTRIES];
   logic [VAL_W-1:0]    stored_value [ENTRIES];
   logic                slot_used    [ENTRIES];

   kv_reply_type        replies_due [$];
   int                  idle_pct;
   int                  mismatch_count;
   int                  n_puts, n_gets, n_removes, n_unused, n_hits, n_refused;

   key_value_table u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_found      (rsp_found),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Table model
   // ---------------------------------------------------------------------

   function automatic logic [KEY_W-1:0] rand_field();
      logic [31:0] r;
      r = $urandom();
      return r[KEY_W-1:0];
   endfunction

   // lowest valid slot holding k, -1 on a miss
   function automatic int slot_of(input logic [KEY_W-1:0] k);
      for (int i = 0; i < ENTRIES; i++)
         if (slot_used[i] && stored_key[i] == k)
            return i;
      return -1;
   endfunction

   function automatic int first_free();
      for (int i = 0; i < ENTRIES; i++)
         if (!slot_used[i])
            return i;
      return -1;
   endfunction

   function automatic int occupancy();
      int n;
      n = 0;
      for (int i = 0; i < ENTRIES; i++)
         n += slot_used[i];
      return n;
   endfunction

   // Applies one accepted word to the model and returns the reply it owes.
   function automatic kv_reply_type apply_request(input logic [TYPE_W-1:0] kind,
                                                  input logic [KEY_W-1:0]  k,
                                                  input logic [VAL_W-1:0]  v);
      kv_reply_type r;
      int           hit;
      int           spare;
      r     = '0;
      hit   = slot_of(k);
      spare = first_free();
      case (kind)
         kvt_pkg::REQ_PUT: begin
            n_puts++;
            if (hit >= 0) begin
               // stored key: overwrite in place, even on a full table
               r.found           = 1'b1;
               stored_value[hit] = v;
            end else if (spare >= 0) begin
               stored_key[spare]   = k;
               stored_value[spare] = v;
               slot_used[spare]    = 1'b1;
            end else begin
               // new key with no free slot: dropped and flagged
               r.status = 1'b1;
               n_refused++;
            end
         end
         kvt_pkg::REQ_GET: begin
            n_gets++;
            if (hit >= 0) begin
               r.found      = 1'b1;
               r.read_value = stored_value[hit];
            end
         end
         kvt_pkg::REQ_REMOVE: begin
            n_removes++;
            if (hit >= 0) begin
               r.found        = 1'b1;
               slot_used[hit] = 1'b0;
            end
         end
         default: n_unused++;   // unused code: no change, all-zero reply
      endcase
      if (r.found)
         n_hits++;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Drives one word at the falling edge, holds it until an edge with busy
   // low takes it, then books the reply. start stays high on return so that
   // back-to-back words follow with no idle gap.
   task automatic send_word(input logic [TYPE_W-1:0] kind,
                            input logic [KEY_W-1:0]  k,
                            input logic [VAL_W-1:0]  v);
      int gap;
      gap = 0;
      if ($urandom_range(99) < idle_pct)
         // mostly short gaps, sometimes one as long as a full miss scan
         gap = ($urandom_range(3) == 0) ? $urandom_range(ENTRIES + 4, 1)
                                        : $urandom_range(3, 1);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start     <= 1'b1;
      req_type  <= kind;
      req_key   <= k;
      req_value <= v;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      replies_due.push_back(apply_request(kind, k, v));
   endtask

   // Drops start and waits for every booked reply.
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (replies_due.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Reply checker: replies come back in request order, one per word
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      kv_reply_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (replies_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: reply with none pending: expected nothing, %s%0b %s%0h %s%0b",
                     $time, "actual found=", rsp_found, "value=", rsp_read_value,
                     "status=", rsp_status);
         end else begin
            want = replies_due.pop_front();
            if (rsp_found !== want.found) begin
               mismatch_count++;
               $display("%0t: found mismatch: expected %0b, actual %0b",
                        $time, want.found, rsp_found);
            end
            if (rsp_read_value !== want.read_value) begin
               mismatch_count++;
               $display("%0t: read_value mismatch: expected %0h, actual %0h",
                        $time, want.read_value, rsp_read_value);
            end
            if (rsp_status !== want.status) begin
               mismatch_count++;
               $display("%0t: status mismatch: expected %0b, actual %0b",
                        $time, want.status, rsp_status);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Right after the clearing pass: nothing is stored.
   task automatic test_empty_table();
      send_word(kvt_pkg::REQ_GET,    '0,        rand_field());
      send_word(kvt_pkg::REQ_REMOVE, FIELD_MAX, rand_field());
      send_word(kvt_pkg::REQ_GET,    FIELD_MAX, '0);
      send_word(REQ_UNUSED,          '0,        FIELD_MAX);
   endtask

   // Field extremes, overwrite, remove of a missing key, slot reuse.
   task automatic test_basic_ops();
      send_word(kvt_pkg::REQ_PUT,    '0,            FIELD_MAX);
      send_word(kvt_pkg::REQ_PUT,    FIELD_MAX,     '0);
      send_word(kvt_pkg::REQ_GET,    '0,            '0);
      send_word(kvt_pkg::REQ_GET,    FIELD_MAX,     FIELD_MAX);
      send_word(kvt_pkg::REQ_PUT,    '0,            31'h2AAA_AAAA);
      send_word(kvt_pkg::REQ_GET,    '0,            '0);
      send_word(REQ_UNUSED,          FIELD_MAX,     31'h1234_5678);
      send_word(kvt_pkg::REQ_GET,    FIELD_MAX,     '0);
      send_word(kvt_pkg::REQ_REMOVE, FIELD_MAX,     '0);
      send_word(kvt_pkg::REQ_REMOVE, FIELD_MAX,     '0);
      send_word(kvt_pkg::REQ_GET,    FIELD_MAX,     '0);
      send_word(kvt_pkg::REQ_PUT,    31'h5555_5555, 31'h5555_5555);
      send_word(kvt_pkg::REQ_GET,    31'h5555_5555, '0);
      send_word(kvt_pkg::REQ_REMOVE, '0,            FIELD_MAX);
      send_word(kvt_pkg::REQ_GET,    '0,            '0);
      send_word(kvt_pkg::REQ_PUT,    FIELD_MAX,     31'd1);
   endtask

   // Fills every slot, then: refused new key, overwrite while full,
   // remove and reinsert into the freed slot, hit on the last slot.
   task automatic test_full_table();
      logic [KEY_W-1:0] k;
      logic [KEY_W-1:0] kept;
      idle_pct = 20;
      while (occupancy() < ENTRIES) begin
         k = rand_field();
         if (slot_of(k) < 0)
            send_word(kvt_pkg::REQ_PUT, k, rand_field());
      end
      do
         k = rand_field();
      while (slot_of(k) >= 0);
      send_word(kvt_pkg::REQ_PUT, k, rand_field());
      send_word(kvt_pkg::REQ_GET, k, rand_field());
      kept = stored_key[0];
      send_word(kvt_pkg::REQ_PUT, kept, FIELD_MAX);
      send_word(kvt_pkg::REQ_GET, kept, '0);
      send_word(kvt_pkg::REQ_REMOVE, stored_key[ENTRIES/2], rand_field());
      send_word(kvt_pkg::REQ_PUT, k, rand_field());
      send_word(kvt_pkg::REQ_GET, k, '0);
      send_word(kvt_pkg::REQ_GET, stored_key[ENTRIES-1], '0);
      send_word(kvt_pkg::REQ_PUT, rand_field() | 31'h4000_0000, rand_field());
      // hold off until the table is quiet before moving on
      wait_drained();
   endtask

   // Removes every stored key, then looks one of them up again.
   task automatic test_clear_out();
      logic [KEY_W-1:0] held [$];
      for (int i = ENTRIES - 1; i >= 0; i--)
         if (slot_used[i])
            held.push_back(stored_key[i]);
      foreach (held[i])
         send_word(kvt_pkg::REQ_REMOVE, held[i], rand_field());
      send_word(kvt_pkg::REQ_GET, (held.size() != 0) ? held[0] : '0, rand_field());
   endtask

   // Mostly keys from a small pool so hits, removes and a full table are
   // common; one word in ten uses a fresh random key. Then removes every stored key.
   task automatic test_random_traffic(input int pct, input int count);
      logic [KEY_W-1:0] pool [KEY_POOL];
      logic [KEY_W-1:0] k;
      int               pick;
      idle_pct = pct;
      foreach (pool[i])
         pool[i] = rand_field();
      pool[0] = '0;
      pool[1] = FIELD_MAX;
      repeat (count) begin
         k    = ($urandom_range(9) == 0) ? rand_field() : pool[$urandom_range(KEY_POOL - 1)];
         pick = $urandom_range(99);
         if (pick < 45)
            send_word(kvt_pkg::REQ_PUT, k, rand_field());
         else if (pick < 75)
            send_word(kvt_pkg::REQ_GET, k, rand_field());
         else if (pick < 95)
            send_word(kvt_pkg::REQ_REMOVE, k, rand_field());
         else
            send_word(REQ_UNUSED, k, rand_field());
      end
      test_clear_out();
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_type  = kvt_pkg::REQ_PUT;
      req_key   = '0;
      req_value = '0;
      idle_pct  = 33;
      mismatch_count = 0;
      n_puts = 0; n_gets = 0; n_removes = 0; n_unused = 0; n_hits = 0; n_refused = 0;
      foreach (slot_used[i]) begin
         slot_used[i]    = 1'b0;
         stored_key[i]   = '0;
         stored_value[i] = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // the clearing pass after reset keeps busy high; send_word waits it out
      test_empty_table();
      test_basic_ops();
      test_full_table();
      test_clear_out();
      test_random_traffic(33, 180);
      test_random_traffic(55, 180);
      test_random_traffic(0, 180);

      wait_drained();
      repeat (SETTLE_TICKS) @(posedge clock);
      $display("Covered %0d puts, %0d gets, %0d removes, %0d unused-code words;",
               n_puts, n_gets, n_removes, n_unused);
      $display("%0d key hits and %0d puts refused on a full table.", n_hits, n_refused);
      if (mismatch_count == 0 && replies_due.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // worst case is roughly 900 words
   initial begin
      #3_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
